// ===== hdl/rlim_pkg.sv =====
// ---------------------------------------------------------------------------
// Rate limiter package
// Shared types, constants and codes for the per-client window rate limiter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlim_pkg;

    localparam int MAX_CLIENTS    = 16;
    localparam int SLOT_W         = $clog2(MAX_CLIENTS);
    localparam int WIN_SECONDS    = 60;
    localparam int SEC_W          = 6;
    localparam int BYTES_W        = 31;
    localparam int ADDR_W         = 32;
    localparam int BKT_AW         = SLOT_W + SEC_W;
    localparam int PADDR_W        = 3;

    localparam logic [3:0]         BLOCK_TICKS  = 4'd10;
    localparam logic [SEC_W-1:0]   NO_SECOND    = 6'd63;
    localparam logic [SEC_W-1:0]   WIN_LAST     = 6'(WIN_SECONDS);
    localparam logic [BYTES_W-1:0] SAT31        = 31'h7FFF_FFFF;
    localparam logic [BYTES_W-1:0] LIMIT_RESET  = 31'd65536;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_BLOCKED = 3'd2;
    localparam logic [2:0] ST_NEWBLK  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [PADDR_W-1:0] REG_BYTE_LIMIT = 3'd0;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [ADDR_W-1:0]  client_address;
        logic [BYTES_W-1:0] request_bytes;
        logic [SEC_W-1:0]   current_second;
    } rlim_in_t;

    typedef struct packed {
        logic       allowed;
        logic       is_blocked_now;
        logic [2:0] status;
    } rlim_out_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]         op;
        logic               hit;
        logic               full;
        logic [SLOT_W-1:0]  slot;
        logic [BYTES_W-1:0] bytes;
        logic [SEC_W-1:0]   sec;
    } rlim_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rlim_front.sv =====
// ---------------------------------------------------------------------------
// Rate limiter front end
// Accepts words, looks the address up in the client table, allocates slots
// for new clients and emits classified commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlim_front import rlim_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire rlim_in_t  s_data,
    output logic           cmd_valid,
    input  wire logic      cmd_ready,
    output rlim_cmd_t      cmd_data
);

    logic [MAX_CLIENTS-1:0] valid_reg;
    logic [ADDR_W-1:0]      ip_reg [MAX_CLIENTS];

    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              has_free;
    logic [SLOT_W-1:0] free_slot;
    logic [SEC_W-1:0]  sec;
    logic              accept;

    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && ip_reg[i] == s_data.client_address) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                has_free  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign sec = (s_data.current_second >= WIN_LAST) ?
                 s_data.current_second - WIN_LAST : s_data.current_second;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    always_comb begin
        cmd_data.op    = s_data.opcode;
        cmd_data.hit   = hit;
        cmd_data.full  = !hit && !has_free;
        cmd_data.slot  = hit ? hit_slot : free_slot;
        cmd_data.bytes = s_data.request_bytes;
        cmd_data.sec   = sec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (accept && s_data.opcode == OP_ADD && !hit && has_free) begin
            valid_reg[free_slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.opcode == OP_ADD && !hit && has_free) begin
            ip_reg[free_slot] <= s_data.client_address;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rlim_queue.sv =====
// ---------------------------------------------------------------------------
// Rate limiter command queue
// Two-entry queue between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlim_queue import rlim_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire rlim_cmd_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output rlim_cmd_t      out_data
);

    rlim_cmd_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rlim_back.sv =====
// ---------------------------------------------------------------------------
// Rate limiter back end
// Sequencer that owns the bucket memory and per-client state and carries out
// each command, then presents its result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlim_back import rlim_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [BYTES_W-1:0] byte_limit,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire rlim_cmd_t        cmd_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output rlim_out_t             m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DECIDE,
        S_CLEAR,
        S_TICK,
        S_OUT
    } state_t;

    localparam rlim_out_t RES_OK = '{allowed: 1'b0, is_blocked_now: 1'b0, status: ST_OK};

    state_t                 state_reg;
    rlim_cmd_t              cur_reg;
    rlim_out_t              res_reg;
    logic                   m_valid_reg;
    rlim_out_t              m_data_reg;
    logic [SEC_W-1:0]       idx_reg;
    logic                   rd_vld_reg;
    logic [BYTES_W-1:0]     acc_reg;
    logic [SLOT_W-1:0]      ci_reg;
    logic [SLOT_W-1:0]      clr_slot_reg;
    logic                   clr_tick_reg;
    logic [MAX_CLIENTS-1:0] valid_reg;
    logic [MAX_CLIENTS-1:0] blocked_reg;
    logic [3:0]             cnt_reg  [MAX_CLIENTS];
    logic [SEC_W-1:0]       last_reg [MAX_CLIENTS];

    logic [BYTES_W-1:0] bkt_mem [2**BKT_AW];
    logic [BYTES_W-1:0] rd_data_reg;

    logic               mem_we;
    logic [BKT_AW-1:0]  mem_wa;
    logic [BYTES_W-1:0] mem_wd;
    logic [BKT_AW-1:0]  rd_addr;
    logic [BYTES_W:0]   acc_sum;
    logic [BYTES_W:0]   tot_sum;
    logic [BYTES_W-1:0] tot_sat;
    logic               over;
    logic               tick_hit;
    logic               out_free;

    assign acc_sum  = {1'b0, acc_reg} + {1'b0, rd_data_reg};
    assign tot_sum  = {1'b0, acc_reg} + {1'b0, cur_reg.bytes};
    assign tot_sat  = tot_sum[BYTES_W] ? SAT31 : tot_sum[BYTES_W-1:0];
    assign over     = tot_sat >= byte_limit;
    assign tick_hit = valid_reg[ci_reg] && last_reg[ci_reg] != cur_reg.sec;
    assign out_free = !m_valid_reg || m_ready;

    assign cmd_ready = state_reg == S_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign rd_addr   = {cur_reg.slot, idx_reg};

    always_comb begin
        mem_we = 1'b0;
        mem_wa = {cur_reg.slot, cur_reg.sec};
        mem_wd = '0;
        case (state_reg)
            S_DECIDE: begin
                mem_we = !over;
                mem_wd = cur_reg.bytes;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = {clr_slot_reg, idx_reg};
            end
            S_TICK: begin
                mem_we = tick_hit;
                mem_wa = {ci_reg, cur_reg.sec};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bkt_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= bkt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            valid_reg   <= '0;
            blocked_reg <= '0;
            for (int i = 0; i < MAX_CLIENTS; i++) begin
                cnt_reg[i]  <= 4'd0;
                last_reg[i] <= NO_SECOND;
            end
        end else begin
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg <= (state_reg == S_SUM) && (idx_reg < WIN_LAST);
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cur_reg <= cmd_data;
                        idx_reg <= '0;
                        acc_reg <= '0;
                        ci_reg  <= '0;
                        case (cmd_data.op)
                            OP_ADD: begin
                                if (cmd_data.full) begin
                                    res_reg   <= '{allowed: 1'b0, is_blocked_now: 1'b0,
                                                   status: ST_FULL};
                                    state_reg <= S_OUT;
                                end else if (cmd_data.hit) begin
                                    res_reg   <= '{allowed: 1'b0,
                                                   is_blocked_now: blocked_reg[cmd_data.slot],
                                                   status: ST_OK};
                                    state_reg <= S_OUT;
                                end else begin
                                    res_reg <= RES_OK;
                                    valid_reg[cmd_data.slot]   <= 1'b1;
                                    blocked_reg[cmd_data.slot] <= 1'b0;
                                    cnt_reg[cmd_data.slot]     <= 4'd0;
                                    last_reg[cmd_data.slot]    <= NO_SECOND;
                                    clr_slot_reg <= cmd_data.slot;
                                    clr_tick_reg <= 1'b0;
                                    state_reg    <= S_CLEAR;
                                end
                            end
                            OP_TICK: begin
                                res_reg   <= RES_OK;
                                state_reg <= S_TICK;
                            end
                            default: begin
                                // Send and query share the lookup outcomes.
                                if (!cmd_data.hit) begin
                                    res_reg   <= '{allowed: 1'b0, is_blocked_now: 1'b0,
                                                   status: ST_UNKNOWN};
                                    state_reg <= S_OUT;
                                end else if (blocked_reg[cmd_data.slot]) begin
                                    cnt_reg[cmd_data.slot] <= BLOCK_TICKS;
                                    res_reg   <= '{allowed: 1'b0, is_blocked_now: 1'b1,
                                                   status: ST_BLOCKED};
                                    state_reg <= S_OUT;
                                end else if (cmd_data.op == OP_SEND) begin
                                    res_reg   <= RES_OK;
                                    state_reg <= S_SUM;
                                end else begin
                                    res_reg   <= RES_OK;
                                    state_reg <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    if (idx_reg < WIN_LAST) begin
                        idx_reg <= idx_reg + 6'd1;
                    end
                    if (rd_vld_reg) begin
                        acc_reg <= acc_sum[BYTES_W] ? SAT31 : acc_sum[BYTES_W-1:0];
                    end
                    if (idx_reg == WIN_LAST && !rd_vld_reg) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (over) begin
                        blocked_reg[cur_reg.slot] <= 1'b1;
                        cnt_reg[cur_reg.slot]     <= BLOCK_TICKS;
                        res_reg <= '{allowed: 1'b0, is_blocked_now: 1'b1, status: ST_NEWBLK};
                    end else begin
                        last_reg[cur_reg.slot] <= cur_reg.sec;
                        res_reg <= '{allowed: 1'b1, is_blocked_now: 1'b0, status: ST_OK};
                    end
                    state_reg <= S_OUT;
                end
                S_CLEAR: begin
                    if (idx_reg == WIN_LAST - 6'd1) begin
                        idx_reg <= '0;
                        if (clr_tick_reg) begin
                            ci_reg    <= ci_reg + SLOT_W'(1);
                            state_reg <= (ci_reg == SLOT_W'(MAX_CLIENTS - 1)) ? S_OUT : S_TICK;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        idx_reg <= idx_reg + 6'd1;
                    end
                end
                S_TICK: begin
                    if (tick_hit && blocked_reg[ci_reg] && cnt_reg[ci_reg] <= 4'd1) begin
                        // Block has run out: unblock and wipe the whole window.
                        cnt_reg[ci_reg]     <= 4'd0;
                        blocked_reg[ci_reg] <= 1'b0;
                        clr_slot_reg        <= ci_reg;
                        clr_tick_reg        <= 1'b1;
                        idx_reg             <= '0;
                        state_reg           <= S_CLEAR;
                    end else begin
                        if (tick_hit && blocked_reg[ci_reg]) begin
                            cnt_reg[ci_reg] <= cnt_reg[ci_reg] - 4'd1;
                        end
                        ci_reg <= ci_reg + SLOT_W'(1);
                        if (ci_reg == SLOT_W'(MAX_CLIENTS - 1)) begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/per_client_window_rate_limiter.sv =====
// Sequence: lookup, query and refused sends go straight to the result; an
// accepted or refused-by-limit send first reads the 60-bucket window; adding a new
// client first clears its 60 buckets; a tick visits each client in turn and
// clears the whole window of each client whose block runs out.
// Throughput is one word at a time through the back-end sequencer.
// Reset is synchronous: the client table empties and byte_limit returns to 65536.
// ---------------------------------------------------------------------------
// Per-client window rate limiter
// Front end, command queue and back-end sequencer, with an APB register port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module per_client_window_rate_limiter import rlim_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rlim_in_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rlim_out_t               m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [BYTES_W-1:0] byte_limit_reg;
    logic               f_valid;
    logic               f_ready;
    rlim_cmd_t          f_data;
    logic               q_valid;
    logic               q_ready;
    rlim_cmd_t          q_data;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BYTE_LIMIT) ? {1'b0, byte_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr == REG_BYTE_LIMIT) begin
            byte_limit_reg <= pwdata[BYTES_W-1:0];
        end
    end

    rlim_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    rlim_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    rlim_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_limit (byte_limit_reg),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd_data   (q_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ===== hdl/rlim_checker.sv =====
// ---------------------------------------------------------------------------
// Rate limiter port checker
// Assertions on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlim_props import rlim_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire rlim_out_t m_data,
    input wire logic      pready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_FULL)
        else $error("status code out of range");

    a_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.allowed |-> m_data.status == ST_OK && !m_data.is_blocked_now)
        else $error("allowed word carries a block indication");

    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_BLOCKED || m_data.status == ST_NEWBLK)
        |-> m_data.is_blocked_now)
        else $error("blocking status without blocked flag");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("register port stalled");

endmodule

bind per_client_window_rate_limiter rlim_props u_rlim_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

`default_nettype wire
